/* sv/component_center_eccentricity_max_macros.svh */
// ----------------------------------------------------------------------------
// component_center_eccentricity_max_macros.svh
// Assertion macros shared by the eccentricity block.
// ----------------------------------------------------------------------------
`ifndef COMPONENT_CENTER_ECCENTRICITY_MAX_MACROS_SVH
`define COMPONENT_CENTER_ECCENTRICITY_MAX_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define CCEM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// An implication that must hold at every rising clock edge outside reset.
`define CCEM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* sv/ccem_pkg.sv */
// ----------------------------------------------------------------------------
// ccem_pkg
// Types and constants of the component center eccentricity block.
// ----------------------------------------------------------------------------
package ccem_pkg;

   localparam int MAX_NODES_DEF    = 64;
   localparam int WEIGHT_BITS_DEF  = 16;
   localparam int CFG_BITS         = 7;
   localparam int ROW_BITS         = 6;
   localparam int VALUE_BITS       = 17;
   localparam int ANSWER_BITS      = 22;
   localparam int NODE_COUNT_RESET = 64;

   localparam logic [ANSWER_BITS-1:0] DIST_LIMIT = '1;

   localparam logic MODE_EDGE = 1'b0;
   localparam logic MODE_COST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_SWEEP,
      ST_SWDRAIN,
      ST_SWCHK,
      ST_SRC,
      ST_SRCRD,
      ST_FIN,
      ST_RELAX,
      ST_RDRAIN,
      ST_RCHK,
      ST_OUT
   } state_type;

endpackage

/* sv/ccem_ram.sv */
// ----------------------------------------------------------------------------
// ccem_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/component_center_eccentricity_max.sv */
// ----------------------------------------------------------------------------
// component_center_eccentricity_max
// Loads a weighted graph and start costs, then finds per-component minimum
// eccentricity by repeated shortest path searches and returns the maximum.
// ----------------------------------------------------------------------------
// Loading takes one request per cycle while the block is idle. After the last
// request, labeling sweeps the edge matrix until a component stops growing, and
// each source repeats relaxation passes, all set by the single edge read port.
// Output is registered; the result is offered once the prior one is taken.
// Reset clears control state and sets node_count to 64; memories keep data.
`include "component_center_eccentricity_max_macros.svh"

module component_center_eccentricity_max #(
   parameter int MAX_NODES   = ccem_pkg::MAX_NODES_DEF,
   parameter int WEIGHT_BITS = ccem_pkg::WEIGHT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [ccem_pkg::ROW_BITS-1:0]     req_row,
   input  logic [ccem_pkg::ROW_BITS-1:0]     req_col,
   input  logic [ccem_pkg::VALUE_BITS-1:0]   req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ccem_pkg::ANSWER_BITS-1:0]  rsp_answer,
   output logic                              rsp_saturated,
   input  logic                              csr_we,
   input  logic [ccem_pkg::CFG_BITS-1:0]     csr_wdata
);

   import ccem_pkg::*;

   localparam int NW         = $clog2(MAX_NODES);
   localparam int CW         = $clog2(MAX_NODES + 1);
   localparam int WB         = WEIGHT_BITS;
   localparam int DW         = WB + NW + 1;
   localparam int EW         = WB + 1;
   localparam int EDGE_AW    = 2 * NW;
   localparam int EDGE_DEPTH = 1 << EDGE_AW;
   localparam logic [32:0] WMAX = 33'((64'd1 << WB) - 64'd1);

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0]    node_count_ff;
   logic [CW-1:0]          n_w;
   logic [CW-1:0]          i_ff, src_ff;
   logic [NW-1:0]          v_ff, w_ff, p_ff;
   logic [NW-1:0]          sw_v_ff, sw_w_ff, rl_w_ff, minidx_ff;
   logic                   sw_vld_ff, rl_vld_ff, grew_ff, found_ff, have_ff;
   logic [MAX_NODES-1:0]   labeled_ff, ingrp_ff, seen_ff, done_ff;
   logic [DW-1:0]          pdist_ff, min_ff;
   logic [ANSWER_BITS-1:0] ecc_ff, low_ff, ans_ff, dsat;
   logic                   sat_ff;
   logic                   rsp_valid_ff, rsp_saturated_ff;
   logic [ANSWER_BITS-1:0] rsp_answer_ff;

   logic                   accept, row_ok, col_ok;
   logic [WB-1:0]          val_clamped;
   logic                   edge_we, cost_we;
   logic [EDGE_AW-1:0]     edge_waddr, edge_raddr;
   logic [EW-1:0]          edge_wdata, edge_rdata;
   logic [WB-1:0]          cost_wdata, cost_rdata;
   logic [DW-1:0]          cand_rdata, cost_sum, newc;
   logic                   cand_we, has_edge, upd, take_min, sweep_hit, pdist_big;
   logic                   v_last, w_last;
   logic [NW-1:0]          i_idx, src_idx;

   // ---------------------------------------------------------------- load path
   assign accept = req_valid && req_ready;
   assign row_ok = 32'(req_row) < 32'(MAX_NODES);
   assign col_ok = 32'(req_col) < 32'(MAX_NODES);

   always_comb begin
      if (33'(req_value[VALUE_BITS-2:0]) > WMAX) begin
         val_clamped = '1;
      end else begin
         val_clamped = WB'(req_value[VALUE_BITS-2:0]);
      end
   end

   // The top bit of an edge word marks a present edge (nonnegative weight).
   assign edge_we    = accept && (req_mode == MODE_EDGE) && row_ok && col_ok;
   assign edge_waddr = {NW'(req_row), NW'(req_col)};
   assign edge_wdata = {~req_value[VALUE_BITS-1], val_clamped};
   assign cost_we    = accept && (req_mode == MODE_COST) && row_ok;
   assign cost_wdata = req_value[VALUE_BITS-1] ? '0 : val_clamped;

   assign edge_raddr = (state_ff == ST_SWEEP) ? {v_ff, w_ff} : {p_ff, w_ff};

   ccem_ram #(.WIDTH(EW), .DEPTH(EDGE_DEPTH)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   ccem_ram #(.WIDTH(WB), .DEPTH(1 << NW)) u_cost_ram (
      .clock (clock),
      .we    (cost_we),
      .waddr (NW'(req_row)),
      .wdata (cost_wdata),
      .raddr (src_idx),
      .rdata (cost_rdata)
   );

   ccem_ram #(.WIDTH(DW), .DEPTH(1 << NW)) u_cand_ram (
      .clock (clock),
      .we    (cand_we),
      .waddr (rl_w_ff),
      .wdata (cost_sum),
      .raddr (w_ff),
      .rdata (cand_rdata)
   );

   // ---------------------------------------------------------------- helpers
   assign n_w     = (32'(node_count_ff) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                          : CW'(node_count_ff);
   assign i_idx   = i_ff[NW-1:0];
   assign src_idx = src_ff[NW-1:0];
   assign v_last  = (CW'(v_ff) == n_w - CW'(1));
   assign w_last  = (CW'(w_ff) == n_w - CW'(1));

   assign pdist_big = 64'(pdist_ff) > 64'(DIST_LIMIT);
   assign dsat      = pdist_big ? DIST_LIMIT : ANSWER_BITS'(pdist_ff);

   // A returned pair grows the current component when its edge is present, the
   // source is a member and the destination is another, still unlabeled node.
   assign sweep_hit = ingrp_ff[sw_v_ff] && (sw_v_ff != sw_w_ff) &&
                      edge_rdata[WB] && !labeled_ff[sw_w_ff];

   // Relaxation of one neighbor, and the running minimum for the next pick.
   assign has_edge = edge_rdata[WB] && (rl_w_ff != p_ff);
   assign cost_sum = pdist_ff + DW'(edge_rdata[WB-1:0]);
   assign upd      = !done_ff[rl_w_ff] && has_edge &&
                     (!seen_ff[rl_w_ff] || (cost_sum < cand_rdata));
   assign newc     = upd ? cost_sum : cand_rdata;
   assign take_min = (seen_ff[rl_w_ff] || upd) && !done_ff[rl_w_ff] &&
                     (!found_ff || (newc < min_ff));
   assign cand_we  = rl_vld_ff && upd;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (i_ff == n_w) begin
               state_in = ST_OUT;
            end else if (!labeled_ff[i_idx]) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (v_last && w_last) begin
               state_in = ST_SWDRAIN;
            end
         end
         ST_SWDRAIN: state_in = ST_SWCHK;
         ST_SWCHK: begin
            state_in = grew_ff ? ST_SWEEP : ST_SRC;
         end
         ST_SRC: begin
            if (src_ff == n_w) begin
               state_in = ST_FIND;
            end else if (ingrp_ff[src_idx]) begin
               state_in = ST_SRCRD;
            end
         end
         ST_SRCRD:  state_in = ST_FIN;
         ST_FIN:    state_in = ST_RELAX;
         ST_RELAX: begin
            if (w_last) begin
               state_in = ST_RDRAIN;
            end
         end
         ST_RDRAIN: state_in = ST_RCHK;
         ST_RCHK: begin
            state_in = found_ff ? ST_FIN : ST_SRC;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = rsp_valid_ff;
      rsp_answer    = rsp_answer_ff;
      rsp_saturated = rsp_saturated_ff;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= CFG_BITS'(NODE_COUNT_RESET);
         labeled_ff    <= '0;
         ingrp_ff      <= '0;
         seen_ff       <= '0;
         done_ff       <= '0;
         sw_vld_ff     <= 1'b0;
         rl_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         sw_vld_ff <= (state_ff == ST_SWEEP);
         sw_v_ff   <= v_ff;
         sw_w_ff   <= w_ff;
         rl_vld_ff <= (state_ff == ST_RELAX);
         rl_w_ff   <= w_ff;
         if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept && req_last) begin
                  i_ff       <= '0;
                  ans_ff     <= '0;
                  sat_ff     <= 1'b0;
                  labeled_ff <= '0;
                  ingrp_ff   <= '0;
               end
            end
            ST_FIND: begin
               if (i_ff != n_w) begin
                  if (labeled_ff[i_idx]) begin
                     i_ff <= i_ff + CW'(1);
                  end else begin
                     labeled_ff[i_idx] <= 1'b1;
                     ingrp_ff          <= MAX_NODES'(1) << i_idx;
                     v_ff              <= '0;
                     w_ff              <= '0;
                     grew_ff           <= 1'b0;
                  end
               end
            end
            ST_SWEEP: begin
               if (w_last) begin
                  w_ff <= '0;
                  v_ff <= v_ff + NW'(1);
               end else begin
                  w_ff <= w_ff + NW'(1);
               end
            end
            ST_SWCHK: begin
               v_ff    <= '0;
               w_ff    <= '0;
               grew_ff <= 1'b0;
               src_ff  <= '0;
               have_ff <= 1'b0;
               low_ff  <= '0;
            end
            ST_SRC: begin
               if (src_ff == n_w) begin
                  if (have_ff && (low_ff > ans_ff)) begin
                     ans_ff <= low_ff;
                  end
                  i_ff <= i_ff + CW'(1);
               end else if (!ingrp_ff[src_idx]) begin
                  src_ff <= src_ff + CW'(1);
               end
            end
            ST_SRCRD: begin
               p_ff     <= src_idx;
               pdist_ff <= DW'(cost_rdata);
               seen_ff  <= MAX_NODES'(1) << src_idx;
               done_ff  <= '0;
               ecc_ff   <= '0;
            end
            ST_FIN: begin
               done_ff[p_ff] <= 1'b1;
               if (pdist_big) begin
                  sat_ff <= 1'b1;
               end
               if (ingrp_ff[p_ff] && (dsat > ecc_ff)) begin
                  ecc_ff <= dsat;
               end
               w_ff     <= '0;
               found_ff <= 1'b0;
            end
            ST_RELAX: begin
               w_ff <= w_ff + NW'(1);
            end
            ST_RCHK: begin
               if (found_ff) begin
                  p_ff     <= minidx_ff;
                  pdist_ff <= min_ff;
               end else begin
                  if (!have_ff || (ecc_ff < low_ff)) begin
                     low_ff <= ecc_ff;
                  end
                  have_ff <= 1'b1;
                  src_ff  <= src_ff + CW'(1);
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_answer_ff    <= ans_ff;
                  rsp_saturated_ff <= sat_ff;
               end
            end
            default: begin
            end
         endcase

         if (sw_vld_ff && sweep_hit) begin
            labeled_ff[sw_w_ff] <= 1'b1;
            ingrp_ff[sw_w_ff]   <= 1'b1;
            grew_ff             <= 1'b1;
         end
         if (rl_vld_ff) begin
            if (upd) begin
               seen_ff[rl_w_ff] <= 1'b1;
            end
            if (take_min) begin
               min_ff    <= newc;
               minidx_ff <= rl_w_ff;
               found_ff  <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- checks
   `CCEM_ASSERT(a_done_seen, (done_ff & ~seen_ff) == '0, "finished node was never reached")
   `CCEM_ASSERT(a_grp_labeled, (ingrp_ff & ~labeled_ff) == '0, "group member not labeled")
   `CCEM_ASSERT_IMPL(a_no_self_write, cand_we, rl_w_ff != p_ff, "candidate write hit the pick")
   `CCEM_ASSERT_IMPL(a_pick_open, (state_ff == ST_RCHK) && found_ff, !done_ff[minidx_ff], "next pick already finished")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Loads random and hand-picked graphs into the eccentricity block, predicts
// the answer of each problem with a software shortest path search, and
// checks every response against it while both handshakes stall at random,
// except while requests 400 to 799 are sent.
module testbench;
   import ccem_pkg::*;

   localparam int NODES = MAX_NODES_DEF;
   localparam int unsigned PATH_CEIL = 4194303;
   localparam int QUIET_CYCLES = 12;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int DENSE_NODES = 16;

   typedef enum logic [1:0] {K_REQ, K_CSR, K_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type             kind;
      logic                    mode;
      logic [ROW_BITS-1:0]     row;
      logic [ROW_BITS-1:0]     col;
      logic [VALUE_BITS-1:0]   value;
      logic                    last;
      logic [CFG_BITS-1:0]     cfg;
   } pending_op_type;

   typedef struct {
      logic [ANSWER_BITS-1:0] answer;
      logic                   saturated;
   } center_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = MODE_EDGE;
   logic [ROW_BITS-1:0] req_row = '0;
   logic [ROW_BITS-1:0] req_col = '0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ANSWER_BITS-1:0] rsp_answer;
   logic rsp_saturated;
   logic csr_we = 1'b0;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   pending_op_type    op_q[$];
   center_result_type answer_q[$];
   logic           req_taken = 1'b0;
   logic           stim_done = 1'b0;
   int             quiet = 0;
   int             req_count = 0;
   int             errors = 0;
   longint         cycles = 0;

   // Shadow copy of the block's graph storage.
   int             edge_w[NODES][NODES];
   int unsigned    start_cost[NODES];
   int unsigned    node_cfg = NODE_COUNT_RESET;

   component_center_eccentricity_max dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_row(req_row), .req_col(req_col), .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_answer(rsp_answer),
      .rsp_saturated(rsp_saturated),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit linked(int a, int b);
      return a != b && edge_w[a][b] >= 0;
   endfunction

   function automatic void solve_graph(output logic [ANSWER_BITS-1:0] ans,
                                       output logic sat);
      int n, groups, i, v, w, k, b, pick;
      int lbl[NODES];
      bit labeled[NODES], seen[NODES], fin[NODES];
      longint cand[NODES];
      int unsigned plen[NODES];
      int unsigned best, low, ecc;
      bit grew, have, found;
      longint d, c;
      n = node_cfg > NODES ? NODES : int'(node_cfg);
      groups = 0;
      best = 0;
      sat = 1'b0;
      for (i = 0; i < NODES; i++) labeled[i] = 0;
      for (i = 0; i < n; i++) begin
         if (!labeled[i]) begin
            labeled[i] = 1;
            lbl[i] = groups;
            grew = 1;
            while (grew) begin
               grew = 0;
               for (v = 0; v < n; v++) begin
                  if (labeled[v] && lbl[v] == groups) begin
                     for (w = 0; w < n; w++) begin
                        if (!labeled[w] && linked(v, w)) begin
                           labeled[w] = 1;
                           lbl[w] = groups;
                           grew = 1;
                        end
                     end
                  end
               end
            end
            groups++;
         end
      end
      for (b = 0; b < groups; b++) begin
         have = 0;
         low = 0;
         for (i = 0; i < n; i++) begin
            if (lbl[i] == b) begin
               for (v = 0; v < n; v++) begin
                  seen[v] = 0;
                  fin[v] = 0;
                  cand[v] = 0;
               end
               cand[i] = start_cost[i];
               seen[i] = 1;
               for (k = 0; k < n; k++) begin
                  found = 0;
                  pick = 0;
                  for (v = 0; v < n; v++) begin
                     if (seen[v] && !fin[v] && (!found || cand[v] < cand[pick])) begin
                        pick = v;
                        found = 1;
                     end
                  end
                  if (!found) break;
                  fin[pick] = 1;
                  d = cand[pick];
                  if (d > PATH_CEIL) begin
                     d = PATH_CEIL;
                     sat = 1'b1;
                  end
                  plen[pick] = int'(d);
                  for (w = 0; w < n; w++) begin
                     if (!fin[w] && linked(pick, w)) begin
                        c = cand[pick] + edge_w[pick][w];
                        if (!seen[w] || c < cand[w]) begin
                           cand[w] = c;
                           seen[w] = 1;
                        end
                     end
                  end
               end
               ecc = 0;
               for (v = 0; v < n; v++) begin
                  if (lbl[v] == b && fin[v] && plen[v] > ecc) ecc = plen[v];
               end
               if (!have || ecc < low) begin
                  low = ecc;
                  have = 1;
               end
            end
         end
         if (have && low > best) best = low;
      end
      ans = best[ANSWER_BITS-1:0];
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("ERROR t=%0t %s: got %0d, expected %0d", $time, field, got, want);
      errors++;
   endtask

   // Driver: requests and register writes change on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (csr_we) begin
         csr_we <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Request still waiting for ready; hold it.
      end else if (op_q.size() == 0) begin
         req_valid <= 1'b0;
         stim_done <= 1'b1;
      end else if (op_q[0].kind != K_REQ) begin
         req_valid <= 1'b0;
         if (answer_q.size() != 0) begin
            quiet <= 0;
         end else if (quiet < QUIET_CYCLES) begin
            quiet <= quiet + 1;
         end else begin
            if (op_q[0].kind == K_CSR) begin
               csr_we <= 1'b1;
               csr_wdata <= op_q[0].cfg;
            end
            void'(op_q.pop_front());
            quiet <= 0;
         end
      end else if (!(req_count >= 400 && req_count < 800) && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_mode <= op_q[0].mode;
         req_row <= op_q[0].row;
         req_col <= op_q[0].col;
         req_value <= op_q[0].value;
         req_last <= op_q[0].last;
         void'(op_q.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (req_count >= 400 && req_count < 800) || $urandom_range(99) >= 34;
      end
   end

   // Monitor: shadows the storage, predicts answers and checks responses.
   always @(posedge clock) begin
      logic signed [VALUE_BITS-1:0] sval;
      center_result_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_we) node_cfg = csr_wdata;
         if (req_valid && req_ready) begin
            req_count++;
            sval = req_value;
            if (req_mode == MODE_EDGE) begin
               edge_w[req_row][req_col] = sval < 0 ? -1 : int'(sval);
            end else begin
               start_cost[req_row] = sval < 0 ? 0 : int'(sval);
            end
            if (req_last) begin
               solve_graph(want.answer, want.saturated);
               answer_q = {answer_q, want};
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_answer, 0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_answer !== want.answer)
                  report_mismatch("answer", rsp_answer, want.answer);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", rsp_saturated, want.saturated);
            end
         end
      end
   end

   task automatic add_req(logic mode, int row, int col, int value, logic last);
      pending_op_type op;
      op.kind = K_REQ;
      op.mode = mode;
      op.row = row[ROW_BITS-1:0];
      op.col = col[ROW_BITS-1:0];
      op.value = value[VALUE_BITS-1:0];
      op.last = last;
      op.cfg = '0;
      op_q = {op_q, op};
   endtask

   task automatic add_ctl(op_kind_type kind, int cfg);
      pending_op_type op;
      op.kind = kind;
      op.mode = MODE_EDGE;
      op.row = '0;
      op.col = '0;
      op.value = '0;
      op.last = 1'b0;
      op.cfg = cfg[CFG_BITS-1:0];
      op_q = {op_q, op};
   endtask

   function automatic int no_edge_value();
      return $urandom_range(1) ? -1 : -int'($urandom_range(65536, 1));
   endfunction

   function automatic int weight_value(int span);
      return $urandom_range(3) == 0 ? 65535 - $urandom_range(span) : $urandom_range(span);
   endfunction

   // One complete problem: every matrix entry and start cost below n is
   // written, in random order, and the final write carries last.
   task automatic add_problem(int n, int density, bit lopsided);
      pending_op_type batch[$];
      pending_op_type op, tmp;
      int r, c, j, span;
      int wt[NODES][NODES];
      span = $urandom_range(1) ? 20 : 65535;
      for (r = 0; r < n; r++) begin
         for (c = 0; c < n; c++) begin
            if (c < r && !lopsided) wt[r][c] = wt[c][r];
            else if ($urandom_range(99) < density) wt[r][c] = weight_value(span);
            else wt[r][c] = no_edge_value();
            if (r == c && $urandom_range(1)) wt[r][c] = weight_value(65535);
         end
      end
      op.kind = K_REQ;
      op.last = 1'b0;
      op.cfg = '0;
      for (r = 0; r < n; r++) begin
         for (c = 0; c < n; c++) begin
            op.mode = MODE_EDGE;
            op.row = r[ROW_BITS-1:0];
            op.col = c[ROW_BITS-1:0];
            op.value = wt[r][c][VALUE_BITS-1:0];
            batch = {batch, op};
         end
         op.mode = MODE_COST;
         op.row = r[ROW_BITS-1:0];
         op.col = ROW_BITS'($urandom_range(63));
         op.value = $urandom_range(5) == 0 ? VALUE_BITS'(no_edge_value())
                                           : VALUE_BITS'(weight_value(span));
         batch = {batch, op};
      end
      // Occasional writes to nodes outside the problem.
      if ($urandom_range(9) == 0 && n < NODES) begin
         for (j = 0; j < 3; j++) begin
            op.mode = logic'($urandom_range(1));
            op.row = ROW_BITS'($urandom_range(NODES - 1, n));
            op.col = ROW_BITS'($urandom_range(63));
            op.value = VALUE_BITS'($urandom);
            batch = {batch, op};
         end
      end
      for (j = batch.size() - 1; j > 0; j--) begin
         r = $urandom_range(j);
         tmp = batch[j];
         batch[j] = batch[r];
         batch[r] = tmp;
      end
      batch[batch.size() - 1].last = 1'b1;
      for (j = 0; j < batch.size(); j++) op_q = {op_q, batch[j]};
   endtask

   initial begin
      int items, problems, n, cur_n;
      // Single node: its eccentricity is its own start cost.
      add_ctl(K_CSR, 1);
      add_req(MODE_EDGE, 0, 0, 0, 1'b0);
      add_req(MODE_COST, 0, 63, 65535, 1'b1);
      // No nodes at all.
      add_ctl(K_CSR, 0);
      add_req(MODE_EDGE, 63, 63, 65535, 1'b1);
      // Two nodes, one-way edge, negative start cost.
      add_ctl(K_CSR, 2);
      add_req(MODE_EDGE, 0, 0, -65536, 1'b0);
      add_req(MODE_EDGE, 0, 1, 65535, 1'b0);
      add_req(MODE_EDGE, 1, 0, -65536, 1'b0);
      add_req(MODE_EDGE, 1, 1, 7, 1'b0);
      add_req(MODE_COST, 0, 0, -1, 1'b0);
      add_req(MODE_COST, 1, 42, 65535, 1'b1);
      // Three nodes: zero-weight link between 0 and 2, node 1 isolated.
      add_ctl(K_CSR, 3);
      add_req(MODE_EDGE, 0, 0, -1, 1'b0);
      add_req(MODE_EDGE, 0, 1, -1, 1'b0);
      add_req(MODE_EDGE, 0, 2, 0, 1'b0);
      add_req(MODE_EDGE, 1, 0, -1, 1'b0);
      add_req(MODE_EDGE, 1, 1, 0, 1'b0);
      add_req(MODE_EDGE, 1, 2, -21845, 1'b0);
      add_req(MODE_EDGE, 2, 0, 0, 1'b0);
      add_req(MODE_EDGE, 2, 1, -1, 1'b0);
      add_req(MODE_EDGE, 2, 2, 65535, 1'b0);
      add_req(MODE_COST, 0, 0, 100, 1'b0);
      add_req(MODE_COST, 1, 21, 43690, 1'b0);
      add_req(MODE_COST, 2, 0, 5, 1'b1);

      items = 0;
      problems = 0;
      cur_n = 3;
      while (items < 1200 || problems < 40) begin
         if (problems == 20) begin
            // A larger dense graph.
            add_ctl(K_CSR, DENSE_NODES);
            add_problem(DENSE_NODES, 100, 1'b0);
            cur_n = DENSE_NODES;
            items += DENSE_NODES * (DENSE_NODES + 1);
         end else begin
            n = $urandom_range(9) == 0 ? $urandom_range(10, 7) : $urandom_range(6, 1);
            if (n != cur_n) add_ctl(K_CSR, n);
            else if ($urandom_range(5) == 0) add_ctl(K_DRAIN, 0);
            cur_n = n;
            add_problem(n, $urandom_range(100), $urandom_range(9) == 0);
            items += n * (n + 1);
         end
         problems++;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (answer_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/ccem_pkg.sv
sv/ccem_ram.sv
sv/component_center_eccentricity_max.sv
tb/testbench.sv
